// ----- rtl/rsfp_pkg.sv -----
// Package with shared constants and types for the running statistics frame publisher.
`default_nettype none
package rsfp_pkg;

  localparam int VALUE_BITS_DEF = 10;
  localparam int COUNT_BITS_DEF = 32;
  localparam int FRAME_BITS     = 32;
  localparam int TOTAL_BITS     = 32;
  localparam int INTERVAL_BITS  = 8;
  localparam logic [INTERVAL_BITS-1:0] INTERVAL_RESET = 8'd4;
  localparam int SNAP_DEPTH     = 4;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_DIVIDE
  } rsfp_state_t;

endpackage
`default_nettype wire

// ----- rtl/rsfp_fifo.sv -----
// Small register queue that carries frame snapshots from the front to the back.
`default_nettype none
module rsfp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  empty
);
  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    mem [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] fill;
  logic                do_wr;
  logic                do_rd;

  assign full    = (fill == CNT_BITS'(DEPTH));
  assign empty   = (fill == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + PTR_BITS'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + PTR_BITS'(1);
      end
      if (do_wr && !do_rd) begin
        fill <= fill + CNT_BITS'(1);
      end else if (do_rd && !do_wr) begin
        fill <= fill - CNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/rsfp_front.sv -----
// Front end that folds each sample into the running statistics and queues frame snapshots.
`default_nettype none
module rsfp_front #(
  parameter int VALUE_BITS = rsfp_pkg::VALUE_BITS_DEF,
  parameter int COUNT_BITS = rsfp_pkg::COUNT_BITS_DEF,
  parameter int SNAP_BITS  = 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                interval_we,
  input  wire logic [rsfp_pkg::INTERVAL_BITS-1:0]  interval_data,
  input  wire logic                                push,
  input  wire logic [VALUE_BITS-1:0]               sample_value,
  input  wire logic                                snap_full,
  output logic                                     snap_push,
  output logic [SNAP_BITS-1:0]                     snap_data
);
  import rsfp_pkg::*;

  localparam int SUM_BITS = VALUE_BITS + COUNT_BITS;

  logic [INTERVAL_BITS-1:0] interval;
  logic [SUM_BITS-1:0]      sum;
  logic [SUM_BITS-1:0]      sum_next;
  logic [COUNT_BITS-1:0]    count;
  logic [COUNT_BITS-1:0]    count_next;
  logic [VALUE_BITS-1:0]    least;
  logic [VALUE_BITS-1:0]    least_next;
  logic [VALUE_BITS-1:0]    greatest;
  logic [VALUE_BITS-1:0]    greatest_next;
  logic [INTERVAL_BITS-1:0] since;
  logic [INTERVAL_BITS-1:0] since_next;
  logic [INTERVAL_BITS-1:0] since_plus;
  logic [FRAME_BITS-1:0]    frames;
  logic [FRAME_BITS-1:0]    frames_next;
  logic                     accept;
  logic                     fire;

  assign accept = push && !snap_full;

  always_comb begin
    sum_next      = sum;
    count_next    = count;
    least_next    = least;
    greatest_next = greatest;
    since_next    = since;
    frames_next   = frames;
    since_plus    = since + INTERVAL_BITS'(1);
    fire          = (since_plus >= interval);
    if (accept) begin
      if (count != {COUNT_BITS{1'b1}}) begin
        sum_next   = sum + SUM_BITS'(sample_value);
        count_next = count + COUNT_BITS'(1);
      end
      if (sample_value < least) begin
        least_next = sample_value;
      end
      if (sample_value > greatest) begin
        greatest_next = sample_value;
      end
      if (fire) begin
        since_next  = '0;
        frames_next = frames + FRAME_BITS'(1);
      end else begin
        since_next = since_plus;
      end
    end
  end

  assign snap_push = accept && fire;
  assign snap_data = {frames_next, count_next, sum_next, least_next, greatest_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      interval <= INTERVAL_RESET;
      sum      <= '0;
      count    <= '0;
      least    <= '1;
      greatest <= '0;
      since    <= '0;
      frames   <= '0;
    end else begin
      if (interval_we) begin
        interval <= interval_data;
      end
      sum      <= sum_next;
      count    <= count_next;
      least    <= least_next;
      greatest <= greatest_next;
      since    <= since_next;
      frames   <= frames_next;
    end
  end

`ifndef ASSERT_OFF
  a_saturated_hold: assert property (@(posedge clk) disable iff (rst)
    (accept && count == {COUNT_BITS{1'b1}}) |=> (count == {COUNT_BITS{1'b1}} && $stable(sum)))
    else $error("saturated count or sum changed");
  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    accept |=> (least <= greatest))
    else $error("running minimum exceeds running maximum");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    snap_push |-> !snap_full)
    else $error("snapshot pushed into a full queue");
`endif

endmodule
`default_nettype wire

// ----- rtl/rsfp_back.sv -----
// Back end that divides each queued snapshot's sum by its count and holds the finished frame.
`default_nettype none
module rsfp_back #(
  parameter int VALUE_BITS = rsfp_pkg::VALUE_BITS_DEF,
  parameter int COUNT_BITS = rsfp_pkg::COUNT_BITS_DEF,
  parameter int SNAP_BITS  = 8
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             snap_empty,
  input  wire logic [SNAP_BITS-1:0]             snap_data,
  output logic                                  snap_pop,
  output logic                                  empty,
  input  wire logic                             pop,
  output logic [rsfp_pkg::FRAME_BITS-1:0]       frame_number,
  output logic [rsfp_pkg::TOTAL_BITS-1:0]       sample_total,
  output logic [VALUE_BITS-1:0]                 mean_value,
  output logic [VALUE_BITS-1:0]                 least_value,
  output logic [VALUE_BITS-1:0]                 greatest_value
);
  import rsfp_pkg::*;

  localparam int SUM_BITS  = VALUE_BITS + COUNT_BITS;
  localparam int IDX_BITS  = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  localparam int MAX_LO    = 0;
  localparam int MIN_LO    = MAX_LO + VALUE_BITS;
  localparam int SUM_LO    = MIN_LO + VALUE_BITS;
  localparam int CNT_LO    = SUM_LO + SUM_BITS;
  localparam int FRM_LO    = CNT_LO + COUNT_BITS;

  rsfp_state_t           state;
  rsfp_state_t           state_next;
  logic [SUM_BITS-1:0]   rem;
  logic [COUNT_BITS-1:0] div;
  logic [VALUE_BITS-1:0] quo;
  logic [IDX_BITS-1:0]   idx;
  logic [FRAME_BITS-1:0] frm;
  logic [VALUE_BITS-1:0] lo;
  logic [VALUE_BITS-1:0] hi;
  logic                  out_valid;
  logic [SUM_BITS-1:0]   dshift;
  logic                  fits;
  logic [SUM_BITS-1:0]   rem_step;
  logic [VALUE_BITS-1:0] quo_step;
  logic                  out_free;
  logic                  step_en;
  logic                  done;

  assign out_free = !out_valid || pop;
  assign empty    = !out_valid;

  always_comb begin
    dshift        = SUM_BITS'(div) << idx;
    fits          = (rem >= dshift);
    rem_step      = fits ? (rem - dshift) : rem;
    quo_step      = quo;
    quo_step[idx] = fits;
  end

  always_comb begin
    state_next = state;
    snap_pop   = 1'b0;
    step_en    = 1'b0;
    done       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (!snap_empty) begin
          snap_pop   = 1'b1;
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (idx != '0) begin
          step_en = 1'b1;
        end else if (out_free) begin
          step_en    = 1'b1;
          done       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (done) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (snap_pop) begin
      frm <= snap_data[FRM_LO +: FRAME_BITS];
      div <= snap_data[CNT_LO +: COUNT_BITS];
      rem <= snap_data[SUM_LO +: SUM_BITS];
      lo  <= snap_data[MIN_LO +: VALUE_BITS];
      hi  <= snap_data[MAX_LO +: VALUE_BITS];
      quo <= '0;
      idx <= IDX_BITS'(VALUE_BITS - 1);
    end else if (step_en) begin
      rem <= rem_step;
      quo <= quo_step;
      idx <= idx - IDX_BITS'(1);
    end
    if (done) begin
      frame_number   <= frm;
      sample_total   <= TOTAL_BITS'(div);
      mean_value     <= (div == '0) ? '0 : quo_step;
      least_value    <= lo;
      greatest_value <= hi;
    end
  end

`ifndef ASSERT_OFF
  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    done |=> (out_valid && state == ST_IDLE))
    else $error("finished division did not load the result");
  a_mean_in_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && sample_total != '0) |->
      (mean_value >= least_value && mean_value <= greatest_value))
    else $error("mean lies outside the minimum to maximum range");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    snap_pop |-> (!snap_empty && state == ST_IDLE))
    else $error("snapshot taken from an empty queue or while busy");
`endif

endmodule
`default_nettype wire

// ----- rtl/running_stats_frame_publisher.sv -----
// A closing sample queues a snapshot that the back end then pops, divides and registers.
// Throughput: one sample per cycle while full is low; the divider in the back end works on
// one frame at a time, and a four-entry snapshot queue absorbs bursts of frames.
// Full rises only when that queue fills, as frames outpace the divider and the pop side.
// Reset (synchronous, active high) clears sum, count, maximum and frame number, sets the
// minimum to all ones, sets frame_interval to 4 and empties the queue and result register.
`default_nettype none
module running_stats_frame_publisher #(
  parameter int VALUE_BITS = rsfp_pkg::VALUE_BITS_DEF,
  parameter int COUNT_BITS = rsfp_pkg::COUNT_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                frame_interval_we,
  input  wire logic [rsfp_pkg::INTERVAL_BITS-1:0]  frame_interval,
  input  wire logic                                push,
  output logic                                     full,
  input  wire logic [VALUE_BITS-1:0]               sample_value,
  output logic                                     empty,
  input  wire logic                                pop,
  output logic [rsfp_pkg::FRAME_BITS-1:0]          frame_number,
  output logic [rsfp_pkg::TOTAL_BITS-1:0]          sample_total,
  output logic [VALUE_BITS-1:0]                    mean_value,
  output logic [VALUE_BITS-1:0]                    least_value,
  output logic [VALUE_BITS-1:0]                    greatest_value
);
  import rsfp_pkg::*;

  localparam int SNAP_BITS = FRAME_BITS + COUNT_BITS + (VALUE_BITS + COUNT_BITS)
                             + 2 * VALUE_BITS;

  logic                 snap_push;
  logic [SNAP_BITS-1:0] snap_wdata;
  logic                 snap_full;
  logic                 snap_pop;
  logic [SNAP_BITS-1:0] snap_rdata;
  logic                 snap_empty;

  assign full = snap_full;

  rsfp_front #(
    .VALUE_BITS (VALUE_BITS),
    .COUNT_BITS (COUNT_BITS),
    .SNAP_BITS  (SNAP_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .interval_we   (frame_interval_we),
    .interval_data (frame_interval),
    .push          (push),
    .sample_value  (sample_value),
    .snap_full     (snap_full),
    .snap_push     (snap_push),
    .snap_data     (snap_wdata)
  );

  rsfp_fifo #(
    .WIDTH (SNAP_BITS),
    .DEPTH (SNAP_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (snap_push),
    .wr_data (snap_wdata),
    .full    (snap_full),
    .rd_en   (snap_pop),
    .rd_data (snap_rdata),
    .empty   (snap_empty)
  );

  rsfp_back #(
    .VALUE_BITS (VALUE_BITS),
    .COUNT_BITS (COUNT_BITS),
    .SNAP_BITS  (SNAP_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .snap_empty     (snap_empty),
    .snap_data      (snap_rdata),
    .snap_pop       (snap_pop),
    .empty          (empty),
    .pop            (pop),
    .frame_number   (frame_number),
    .sample_total   (sample_total),
    .mean_value     (mean_value),
    .least_value    (least_value),
    .greatest_value (greatest_value)
  );

endmodule
`default_nettype wire

// ----- test/tb.sv -----
// Self-checking testbench for the running statistics frame publisher.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rsfp_pkg::*;

  localparam int VBITS = VALUE_BITS_DEF;
  localparam int SETTLE_CYCLES = (VBITS + 2) * (SNAP_DEPTH + 2);
  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_PHASES = 7;

  typedef struct packed {
    logic [FRAME_BITS-1:0] number;
    logic [TOTAL_BITS-1:0] total;
    logic [VBITS-1:0]      mean;
    logic [VBITS-1:0]      least;
    logic [VBITS-1:0]      greatest;
  } stats_frame_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     frame_interval_we = 1'b0;
  logic [INTERVAL_BITS-1:0] frame_interval = '0;
  logic                     push = 1'b0;
  logic                     full;
  logic [VBITS-1:0]         sample_value = '0;
  logic                     empty;
  logic                     pop = 1'b0;
  logic [FRAME_BITS-1:0]    frame_number;
  logic [TOTAL_BITS-1:0]    sample_total;
  logic [VBITS-1:0]         mean_value;
  logic [VBITS-1:0]         least_value;
  logic [VBITS-1:0]         greatest_value;

  logic [VBITS-1:0]         sample_backlog[$];
  stats_frame_t             frames_due[$];
  int                       error_count = 0;
  int                       cycle_count = 0;

  logic [41:0]              acc_sum = '0;
  logic [TOTAL_BITS-1:0]    acc_count = '0;
  logic [VBITS-1:0]         acc_min = '1;
  logic [VBITS-1:0]         acc_max = '0;
  logic [INTERVAL_BITS-1:0] acc_since = '0;
  logic [FRAME_BITS-1:0]    acc_frames = '0;
  logic [INTERVAL_BITS-1:0] acc_interval = INTERVAL_RESET;

  int                       burst_left = 1;
  int                       gap_left = 0;
  int                       stall_phase = 0;
  int                       stall_mode = 0;

  running_stats_frame_publisher dut (
    .clk              (clk),
    .rst              (rst),
    .frame_interval_we(frame_interval_we),
    .frame_interval   (frame_interval),
    .push             (push),
    .full             (full),
    .sample_value     (sample_value),
    .empty            (empty),
    .pop              (pop),
    .frame_number     (frame_number),
    .sample_total     (sample_total),
    .mean_value       (mean_value),
    .least_value      (least_value),
    .greatest_value   (greatest_value)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  function automatic void fold_sample(input logic [VBITS-1:0] s);
    stats_frame_t f;
    logic [41:0]  quotient;
    if (acc_count != '1) begin
      acc_sum   = acc_sum + 42'(s);
      acc_count = acc_count + 1'b1;
    end
    if (s < acc_min) acc_min = s;
    if (s > acc_max) acc_max = s;
    acc_since = acc_since + 1'b1;
    if (acc_since >= acc_interval) begin
      acc_since  = '0;
      acc_frames = acc_frames + 1'b1;
      quotient   = (acc_count != 0) ? acc_sum / 42'(acc_count) : '0;
      f.number   = acc_frames;
      f.total    = acc_count;
      f.mean     = quotient[VBITS-1:0];
      f.least    = acc_min;
      f.greatest = acc_max;
      frames_due.push_back(f);
    end
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endfunction

  function automatic logic [VBITS-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return VBITS'($urandom_range(0, (1 << VBITS) - 1));
    endcase
  endfunction

  // Sender: bursts of requests separated by random gaps, holding while full is high.
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (frame_interval_we) acc_interval = frame_interval;
      if (push && !full) fold_sample(sample_value);
      if (push && full) begin
        push <= 1'b1;
      end else if (gap_left != 0) begin
        gap_left--;
        push <= 1'b0;
        sample_value <= VBITS'($urandom);
      end else if (sample_backlog.size() != 0) begin
        push <= 1'b1;
        sample_value <= sample_backlog.pop_front();
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        push <= 1'b0;
        sample_value <= VBITS'($urandom);
      end
    end
  end

  // Receiver: the stall pattern changes each time the stall phase counter wraps.
  always @(posedge clk) begin
    stats_frame_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (frames_due.size() == 0) begin
          $display("%0t: unexpected frame, expected none, actual number %0d",
                   $time, frame_number);
          error_count++;
        end else begin
          want = frames_due.pop_front();
          compare_field("frame_number", want.number, frame_number);
          compare_field("sample_total", want.total, sample_total);
          compare_field("mean_value", 32'(want.mean), 32'(mean_value));
          compare_field("least_value", 32'(want.least), 32'(least_value));
          compare_field("greatest_value", 32'(want.greatest), 32'(greatest_value));
        end
      end
      if (stall_phase == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: pop <= 1'b1;
        1: pop <= 1'($urandom_range(0, 1));
        2: pop <= (stall_phase % 4 == 0);
        default: pop <= (stall_phase >= 48);
      endcase
      stall_phase = (stall_phase + 1) % 64;
    end
  end

  task automatic wait_idle();
    @(negedge clk);
    while (sample_backlog.size() != 0 || push) @(negedge clk);
    while (frames_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_interval(input logic [INTERVAL_BITS-1:0] value);
    wait_idle();
    @(posedge clk);
    frame_interval_we <= 1'b1;
    frame_interval <= value;
    @(posedge clk);
    frame_interval_we <= 1'b0;
  endtask

  initial begin
    int phase_interval[RAND_PHASES];
    int phase_items[RAND_PHASES];
    phase_interval = '{255, 1, 5, 0, 0, 3, 2};
    phase_items    = '{260, 60, 100, 40, 120, 80, 40};
    phase_interval[4] = $urandom_range(6, 16);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // The reset interval of four first, with the range widening toward both extremes.
    sample_backlog = '{600, 500, 700, 400, 300, 800, 10'h155, 10'h2AA, 1023, 0, 1};
    // Lowering the interval with three samples already counted closes a frame at once.
    write_interval(8'd1);
    sample_backlog = '{512, 513};
    // With an interval of zero every sample closes a frame.
    write_interval(8'd0);
    sample_backlog = '{7, 1022};

    for (int p = 0; p < RAND_PHASES; p++) begin
      write_interval(INTERVAL_BITS'(phase_interval[p]));
      for (int i = 0; i < phase_items[p]; i++) sample_backlog.push_back(pick_sample());
    end

    wait_idle();
    if (error_count == 0 && frames_due.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
